// ----- hw/rtl/icfb_pkg.sv -----
// Shared types, codes and the CRC_A byte step for the ISO 14443A frame builder.
// Depends on nothing; every other file of the block imports it.
package icfb_pkg;

   // Command codes of the input word.
   localparam logic [2:0] CMD_REQUEST   = 3'd0;
   localparam logic [2:0] CMD_ANTICOLL  = 3'd1;
   localparam logic [2:0] CMD_SELECT    = 3'd2;
   localparam logic [2:0] CMD_READ      = 3'd3;
   localparam logic [2:0] CMD_WRITE_HDR = 3'd4;
   localparam logic [2:0] CMD_WRITE_DAT = 3'd5;
   localparam logic [2:0] CMD_HALT      = 3'd6;

   // Frame bytes.
   localparam logic [7:0] OP_SELECT_CL1 = 8'h93;
   localparam logic [7:0] NVB_ANTICOLL  = 8'h20;
   localparam logic [7:0] NVB_SELECT    = 8'h70;
   localparam logic [7:0] OP_READ       = 8'h30;
   localparam logic [7:0] OP_WRITE      = 8'hA0;
   localparam logic [7:0] OP_HALT       = 8'h50;
   localparam logic [7:0] HALT_PAD      = 8'h00;

   localparam logic [2:0] TX_BITS_SHORT = 3'd7;
   localparam logic [2:0] TX_BITS_FULL  = 3'd0;

   localparam logic [15:0] CRC_A_INIT = 16'h6363;
   localparam logic [15:0] CRC_A_POLY = 16'h8408;

   localparam int unsigned MAX_BODY_BYTES = 7;

   // One classified command as the back end consumes it.
   typedef struct packed {
      logic [MAX_BODY_BYTES-1:0][7:0] byte_list;
      logic [2:0]                     byte_count;
      logic                           append_crc;
      logic                           use_stream;
      logic                           short_frame;
   } icfb_job_type;

   // Folds one byte into a reflected CRC-16 (poly 0x8408).
   function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_A_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/iso14443a_command_frame_builder_top.sv -----
// Top level of the ISO 14443A reader frame builder with CRC_A.
// Depends on icfb_pkg, icfb_front, icfb_queue and icfb_back.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | command, data_byte, block_address, uid, last_data
//   rsp_    | out       | rsp_valid/rsp_stall | frame_byte, tx_bits, last
//
// A command's frame has 1 to 9 bytes; the unused command code yields no byte.
// The back end emits one byte per cycle while a job waits and the output is not stalled.
// The front end keeps accepting words while the queue of QUEUE_DEPTH jobs has room.
// Reset is synchronous and active high; it empties the queue and sets CRC to 0x6363.
// rsp_stall holds the output register and, once the queue fills, raises req_stall.
module iso14443a_command_frame_builder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_block_address,
   input  logic [31:0] req_uid,
   input  logic        req_last_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic [2:0]  rsp_tx_bits,
   output logic        rsp_last
);
   import icfb_pkg::*;

   logic         push, pop, queue_full, queue_empty;
   icfb_job_type push_job, head_job;

   icfb_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .req_block_address (req_block_address),
      .req_uid           (req_uid),
      .req_last_data     (req_last_data),
      .queue_full        (queue_full),
      .push              (push),
      .push_job          (push_job)
   );

   icfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   icfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (!queue_empty),
      .job            (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_tx_bits    (rsp_tx_bits),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- hw/rtl/icfb_front.sv -----
// Front end: accepts command words and turns each into a frame job.
// Depends on icfb_pkg; feeds icfb_queue.
module icfb_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_command,
   input  logic [7:0]        req_data_byte,
   input  logic [7:0]        req_block_address,
   input  logic [31:0]       req_uid,
   input  logic              req_last_data,
   input  logic              queue_full,
   output logic              push,
   output icfb_pkg::icfb_job_type push_job
);
   import icfb_pkg::*;

   logic [7:0] bcc;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign bcc       = req_uid[7:0] ^ req_uid[15:8] ^ req_uid[23:16] ^ req_uid[31:24];

   always_comb begin
      push_job = '0;
      unique case (req_command)
         CMD_REQUEST: begin
            push_job.byte_list[0] = {1'b0, req_data_byte[6:0]};
            push_job.byte_count   = 3'd1;
            push_job.short_frame  = 1'b1;
         end
         CMD_ANTICOLL: begin
            push_job.byte_list[0] = OP_SELECT_CL1;
            push_job.byte_list[1] = NVB_ANTICOLL;
            push_job.byte_count   = 3'd2;
         end
         CMD_SELECT: begin
            push_job.byte_list[0] = OP_SELECT_CL1;
            push_job.byte_list[1] = NVB_SELECT;
            push_job.byte_list[2] = req_uid[7:0];
            push_job.byte_list[3] = req_uid[15:8];
            push_job.byte_list[4] = req_uid[23:16];
            push_job.byte_list[5] = req_uid[31:24];
            push_job.byte_list[6] = bcc;
            push_job.byte_count   = 3'd7;
            push_job.append_crc   = 1'b1;
         end
         CMD_READ: begin
            push_job.byte_list[0] = OP_READ;
            push_job.byte_list[1] = req_block_address;
            push_job.byte_count   = 3'd2;
            push_job.append_crc   = 1'b1;
         end
         CMD_WRITE_HDR: begin
            push_job.byte_list[0] = OP_WRITE;
            push_job.byte_list[1] = req_block_address;
            push_job.byte_count   = 3'd2;
            push_job.append_crc   = 1'b1;
         end
         CMD_WRITE_DAT: begin
            push_job.byte_list[0] = req_data_byte;
            push_job.byte_count   = 3'd1;
            push_job.use_stream   = 1'b1;
            push_job.append_crc   = req_last_data;
         end
         CMD_HALT: begin
            push_job.byte_list[0] = OP_HALT;
            push_job.byte_list[1] = HALT_PAD;
            push_job.byte_count   = 3'd2;
            push_job.append_crc   = 1'b1;
         end
         default: begin
            // The unused code only clears the running CRC: an empty job.
            push_job.byte_count = 3'd0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/icfb_queue.sv -----
// Short job queue between the front and back ends.
// Depends on icfb_pkg for the job type.
module icfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  icfb_pkg::icfb_job_type push_job,
   input  logic                   pop,
   output logic                   full,
   output logic                   empty,
   output icfb_pkg::icfb_job_type head_job
);
   import icfb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   icfb_job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("job queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("job queue read while empty");

endmodule

// ----- hw/rtl/icfb_back.sv -----
// Back end: walks the head job one frame byte per cycle unless the output stalls, keeps
// CRC_A and drives the registered result port. Depends on icfb_pkg.
module icfb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  icfb_pkg::icfb_job_type job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_frame_byte,
   output logic [2:0]             rsp_tx_bits,
   output logic                   rsp_last
);
   import icfb_pkg::*;

   logic [3:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [2:0]  rsp_bits_ff, rsp_bits_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [3:0]  total;
   logic        out_free, step, zero_job, emit, final_step, is_body, fold;
   logic [15:0] cur_crc;
   logic [7:0]  body_byte, out_byte;

   assign total      = {1'b0, job.byte_count} + (job.append_crc ? 4'd2 : 4'd0);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step       = job_valid && out_free;
   assign zero_job   = (total == 4'd0);
   assign emit       = step && !zero_job;
   assign final_step = step && (zero_job || (pos_ff == total - 4'd1));
   assign pop        = final_step;
   assign is_body    = (pos_ff < {1'b0, job.byte_count});
   assign fold       = job.append_crc || job.use_stream;
   // A fixed frame starts from the initial value; a payload stream carries on.
   assign cur_crc    = (pos_ff == 4'd0 && !job.use_stream) ? CRC_A_INIT : crc_ff;
   assign body_byte  = job.byte_list[pos_ff[2:0]];

   always_comb begin
      if (is_body) begin
         out_byte = body_byte;
      end else if (pos_ff == {1'b0, job.byte_count}) begin
         out_byte = cur_crc[7:0];
      end else begin
         out_byte = cur_crc[15:8];
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_byte_in = out_byte;
         rsp_bits_in = job.short_frame ? TX_BITS_SHORT : TX_BITS_FULL;
         // An unfinished payload word ends nothing.
         rsp_last_in = final_step && !(job.use_stream && !job.append_crc);
      end
      if (step) begin
         pos_in = final_step ? 4'd0 : pos_ff + 4'd1;
         if (final_step && (job.append_crc || !job.use_stream)) begin
            crc_in = CRC_A_INIT;
         end else if (emit && is_body && fold) begin
            crc_in = crc_a_byte(cur_crc, body_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 4'd0;
         crc_ff       <= CRC_A_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_tx_bits    = rsp_bits_ff;
   assign rsp_last       = rsp_last_ff;

   a_pos_in_job: assert property (@(posedge clock) disable iff (reset)
      (job_valid && !zero_job) |-> (pos_ff < total))
      else $error("byte position ran past the end of the job");
   a_crc_cleared_after_frame: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_last_in) |=> (crc_ff == CRC_A_INIT))
      else $error("CRC not returned to its initial value after a frame");
   a_pos_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !job_valid |-> (pos_ff == 4'd0))
      else $error("byte position left nonzero with no job");

endmodule

// ----- tb/iso14443a_command_frame_builder_top_tb.sv -----
// Self-checking testbench for the ISO 14443A command frame builder top level.
// Depends on icfb_pkg and iso14443a_command_frame_builder_top.
`timescale 1ns / 1ps

module iso14443a_command_frame_builder_top_tb;
   import icfb_pkg::*;

   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int RANDOM_WORDS = 450;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_WORDS = 50;

   typedef struct {
      logic [2:0]  command;
      logic [7:0]  data_byte;
      logic [7:0]  block_address;
      logic [31:0] uid;
      logic        last_data;
   } cmd_word_type;

   typedef struct {
      logic [7:0] frame_byte;
      logic [2:0] tx_bits;
      logic       last;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [7:0]  req_data_byte = '0;
   logic [7:0]  req_block_address = '0;
   logic [31:0] req_uid = '0;
   logic        req_last_data = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic [2:0]  rsp_tx_bits;
   logic        rsp_last;

   cmd_word_type   cmd_backlog[$];
   frame_byte_type frame_expect[$];
   cmd_word_type   next_word;
   cmd_word_type   seen_word;
   frame_byte_type oldest;
   logic [15:0] payload_crc = CRC_A_INIT;
   logic        req_taken = 1'b0;
   int          words_accepted = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct;
   int          recv_stall_pct;

   iso14443a_command_frame_builder_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .req_block_address (req_block_address),
      .req_uid           (req_uid),
      .req_last_data     (req_last_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_tx_bits       (rsp_tx_bits),
      .rsp_last          (rsp_last)
   );

   always #5 clock = ~clock;

   // The idle pattern moves through its phases as words are accepted.
   always_comb begin
      case ((words_accepted / PHASE_WORDS) % 4)
         1: begin
            send_idle_pct = 71;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 71;
         end
         3: begin
            send_idle_pct = 6;
            recv_stall_pct = 6;
         end
         default: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
      endcase
   end

   // Reflected CRC-16 step, fed one data bit at a time, LSB first.
   function automatic logic [15:0] crc_a_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         r = (r[0] ^ b[i]) ? ((r >> 1) ^ CRC_A_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic void expect_byte(input logic [7:0] b, input logic [2:0] bits,
                                       input logic fin);
      frame_byte_type e;
      e.frame_byte = b;
      e.tx_bits = bits;
      e.last = fin;
      frame_expect.push_back(e);
   endfunction

   // Queues a full-length frame body followed by its own CRC_A, low byte first.
   function automatic void expect_crc_frame(input logic [7:0] body[7], input int n);
      logic [15:0] crc;
      crc = CRC_A_INIT;
      for (int i = 0; i < n; i++) begin
         crc = crc_a_fold(crc, body[i]);
         expect_byte(body[i], TX_BITS_FULL, 1'b0);
      end
      expect_byte(crc[7:0], TX_BITS_FULL, 1'b0);
      expect_byte(crc[15:8], TX_BITS_FULL, 1'b1);
   endfunction

   // Works out the frame bytes one accepted command word produces.
   function automatic void build_frame(input cmd_word_type w);
      logic [7:0] body[7];
      logic [7:0] bcc;
      body = '{default: 8'h00};
      if (w.command == CMD_WRITE_DAT) begin
         payload_crc = crc_a_fold(payload_crc, w.data_byte);
         expect_byte(w.data_byte, TX_BITS_FULL, 1'b0);
         if (w.last_data) begin
            expect_byte(payload_crc[7:0], TX_BITS_FULL, 1'b0);
            expect_byte(payload_crc[15:8], TX_BITS_FULL, 1'b1);
            payload_crc = CRC_A_INIT;
         end
         return;
      end
      // Any other command drops an unfinished payload.
      payload_crc = CRC_A_INIT;
      case (w.command)
         CMD_REQUEST: begin
            expect_byte({1'b0, w.data_byte[6:0]}, TX_BITS_SHORT, 1'b1);
         end
         CMD_ANTICOLL: begin
            expect_byte(OP_SELECT_CL1, TX_BITS_FULL, 1'b0);
            expect_byte(NVB_ANTICOLL, TX_BITS_FULL, 1'b1);
         end
         CMD_SELECT: begin
            bcc = w.uid[7:0] ^ w.uid[15:8] ^ w.uid[23:16] ^ w.uid[31:24];
            body = '{OP_SELECT_CL1, NVB_SELECT, w.uid[7:0], w.uid[15:8],
                     w.uid[23:16], w.uid[31:24], bcc};
            expect_crc_frame(body, 7);
         end
         CMD_READ: begin
            body[0] = OP_READ;
            body[1] = w.block_address;
            expect_crc_frame(body, 2);
         end
         CMD_WRITE_HDR: begin
            body[0] = OP_WRITE;
            body[1] = w.block_address;
            expect_crc_frame(body, 2);
         end
         CMD_HALT: begin
            body[0] = OP_HALT;
            body[1] = HALT_PAD;
            expect_crc_frame(body, 2);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (word %0d, cycle %0d)",
               what, got, want, words_accepted, cycle_count);
      mismatch_count++;
   endtask

   task automatic queue_word(input logic [2:0] cmd, input logic [7:0] data,
                             input logic [7:0] addr, input logic [31:0] uid,
                             input logic fin);
      cmd_word_type w;
      w.command = cmd;
      w.data_byte = data;
      w.block_address = addr;
      w.uid = uid;
      w.last_data = fin;
      cmd_backlog.push_back(w);
   endtask

   // Driver: a new word goes out only once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_word = cmd_backlog.pop_front();
            req_valid <= 1'b1;
            req_command <= next_word.command;
            req_data_byte <= next_word.data_byte;
            req_block_address <= next_word.block_address;
            req_uid <= next_word.uid;
            req_last_data <= next_word.last_data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Monitor: predicts on every accepted command word and checks every result byte.
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
      if (reset) begin
         payload_crc = CRC_A_INIT;
      end else begin
         if (req_valid && !req_stall) begin
            seen_word.command = req_command;
            seen_word.data_byte = req_data_byte;
            seen_word.block_address = req_block_address;
            seen_word.uid = req_uid;
            seen_word.last_data = req_last_data;
            build_frame(seen_word);
            words_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_expect.size() == 0) begin
               report_mismatch("unexpected frame_byte", 32'(rsp_frame_byte), 0);
            end else begin
               oldest = frame_expect.pop_front();
               if (rsp_frame_byte !== oldest.frame_byte) begin
                  report_mismatch("frame_byte", 32'(rsp_frame_byte),
                                  32'(oldest.frame_byte));
               end
               if (rsp_tx_bits !== oldest.tx_bits) begin
                  report_mismatch("tx_bits", 32'(rsp_tx_bits), 32'(oldest.tx_bits));
               end
               if (rsp_last !== oldest.last) begin
                  report_mismatch("last", 32'(rsp_last), 32'(oldest.last));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("iso14443a_command_frame_builder_top verification failed");
         $finish;
      end
   end

   initial begin
      int random_words;
      int pick;
      int n;
      random_words = 0;

      // Directed words: field extremes, every command and the corner cases.
      queue_word(CMD_REQUEST, 8'h26, 8'h00, 32'h0, 1'b0);
      queue_word(CMD_REQUEST, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      queue_word(CMD_REQUEST, 8'h00, 8'h00, 32'h0, 1'b0);
      queue_word(CMD_ANTICOLL, 8'h00, 8'h00, 32'h0, 1'b0);
      queue_word(CMD_SELECT, 8'h00, 8'h00, 32'h0000_0000, 1'b0);
      queue_word(CMD_SELECT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      queue_word(CMD_SELECT, 8'h00, 8'h00, 32'hDEAD_BEEF, 1'b0);
      queue_word(CMD_READ, 8'h00, 8'h00, 32'h0, 1'b0);
      queue_word(CMD_READ, 8'h00, 8'hFF, 32'h0, 1'b0);
      queue_word(CMD_WRITE_HDR, 8'h00, 8'h00, 32'h0, 1'b0);
      queue_word(CMD_WRITE_HDR, 8'h00, 8'hFF, 32'h0, 1'b0);
      queue_word(CMD_WRITE_DAT, 8'h00, 8'h00, 32'h0, 1'b0);
      queue_word(CMD_WRITE_DAT, 8'hFF, 8'h00, 32'h0, 1'b0);
      queue_word(CMD_WRITE_DAT, 8'h5A, 8'h00, 32'h0, 1'b1);
      // A payload of a single byte marked last.
      queue_word(CMD_WRITE_DAT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      // An unfinished payload is dropped by a halt.
      queue_word(CMD_WRITE_DAT, 8'h11, 8'h00, 32'h0, 1'b0);
      queue_word(CMD_HALT, 8'h00, 8'h00, 32'h0, 1'b0);
      // The unused code emits nothing but still restarts the CRC.
      queue_word(CMD_WRITE_DAT, 8'h22, 8'h00, 32'h0, 1'b0);
      queue_word(CMD_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      queue_word(CMD_WRITE_DAT, 8'h33, 8'h00, 32'h0, 1'b1);
      queue_word(CMD_HALT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);

      // Random part: mostly well-formed write transfers, mixed with single commands and noise.
      while (random_words < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            queue_word(CMD_WRITE_HDR, 8'($urandom), 8'($urandom), $urandom,
                       1'($urandom));
            n = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 18);
            for (int k = 0; k < n; k++) begin
               queue_word(CMD_WRITE_DAT, 8'($urandom), 8'($urandom), $urandom,
                          k == n - 1);
            end
            random_words += n + 1;
         end else if (pick < 85) begin
            queue_word(3'($urandom_range(0, 6)), 8'($urandom), 8'($urandom), $urandom,
                       1'($urandom));
            random_words++;
         end else begin
            queue_word(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), $urandom,
                       1'($urandom_range(0, 1)));
            random_words++;
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (cmd_backlog.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      while (frame_expect.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && frame_expect.size() == 0) begin
         $display("iso14443a_command_frame_builder_top verification clean");
      end else begin
         $display("iso14443a_command_frame_builder_top verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/icfb_pkg.sv
hw/rtl/icfb_front.sv
hw/rtl/icfb_queue.sv
hw/rtl/icfb_back.sv
hw/rtl/iso14443a_command_frame_builder_top.sv
tb/iso14443a_command_frame_builder_top_tb.sv
